// ===== design/epc_pkg.sv =====
`timescale 1ns / 1ps
// Elevator position controller: shared types, codes and constants.
// No dependencies.
package epc_pkg;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SET    = 2'd1,
        KIND_PRESET = 2'd2,
        KIND_HOME   = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_GAIN      = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED = 2'd1;
    localparam logic [1:0] CFG_LEEWAY    = 2'd2;

    localparam logic [15:0] GAIN_RESET      = 16'd256;
    localparam logic [14:0] MAX_SPEED_RESET = 15'd8192;
    localparam logic [7:0]  LEEWAY_RESET    = 8'd8;
    localparam logic [14:0] MAX_DRIVE       = 15'd16384;

    typedef struct packed {
        logic [15:0] gain;
        logic [14:0] max_eff;
        logic [7:0]  leeway;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] position;
        logic               limit_clear;
        logic               button_pressed;
        logic signed [15:0] target_value;
        logic [2:0]         preset_index;
    } t_item;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               brake;
        logic               homing;
        logic               at_target;
    } t_result;

    // Preset k sits at k/2 ft, i.e. k * 128 in 1/256 ft.
    function automatic logic [10:0] preset_height(input logic [3:0] k);
        preset_height = {k, 7'b0};
    endfunction

endpackage

// ===== design/elevator_position_controller.sv =====
`timescale 1ns / 1ps
// Elevator position controller top level: input register, controller law,
// result register. Depends on epc_pkg, epc_cfg and epc_law.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------
//  input   | i_in_valid / o_in_ready  | i_kind, i_position, i_limit_clear,
//          |                          | i_button_pressed, i_target_value, i_preset_index
//  result  | o_out_valid / i_out_ready| o_drive, o_brake, o_homing, o_at_target
//  config  | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
// One item per cycle unless a held result stalls a tick. A tick passes the input
// register, then the result register; each takes a new transfer while the next
// stage drains, so a held result stalls the input only once both are full.
// Commands produce no result and never wait on the result side.
// Reset is synchronous; it clears the controller state and sets the configuration to its reset values.
module elevator_position_controller import epc_pkg::*; #(
    parameter int NUM_PRESETS = 6,
    parameter int POS_WIDTH   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_position,
    input  logic               i_limit_clear,
    input  logic               i_button_pressed,
    input  logic signed [15:0] i_target_value,
    input  logic [2:0]         i_preset_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_drive,
    output logic               o_brake,
    output logic               o_homing,
    output logic               o_at_target,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out, law_res;
    logic    r_out_valid;
    logic    tick, out_free, go;

    epc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    epc_law #(
        .NUM_PRESETS (NUM_PRESETS),
        .POS_WIDTH   (POS_WIDTH)
    ) u_law (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (law_res)
    );

    assign tick       = (r_in.kind == KIND_TICK);
    assign out_free   = !r_out_valid || i_out_ready;
    assign go         = r_in_valid && (!tick || out_free);
    assign o_in_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.kind           <= t_kind'(i_kind);
            r_in.position       <= i_position;
            r_in.limit_clear    <= i_limit_clear;
            r_in.button_pressed <= i_button_pressed;
            r_in.target_value   <= i_target_value;
            r_in.preset_index   <= i_preset_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && tick) begin
            r_out <= law_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out.drive;
    assign o_brake     = r_out.brake;
    assign o_homing    = r_out.homing;
    assign o_at_target = r_out.at_target;

`ifndef SYNTHESIS
    a_homing_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_homing |-> !o_brake && !o_at_target && o_drive <= 16'sd0)
        else $error("homing result carries brake or target flag");

    a_brake_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_homing |-> o_brake == o_at_target)
        else $error("brake differs from at_target");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive <= 16'sd16384 && o_drive >= -16'sd16384)
        else $error("drive outside full scale");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !go |=> r_in_valid && $stable(r_in))
        else $error("stalled input register lost its item");

    a_cmd_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && !tick && !r_out_valid |=> !o_out_valid)
        else $error("command produced a result");
`endif

endmodule

// ===== design/epc_cfg.sv =====
`timescale 1ns / 1ps
// Elevator position controller: configuration registers.
// Depends on epc_pkg.
module epc_cfg import epc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    logic [15:0] r_gain;
    logic [14:0] r_max_speed;
    logic [7:0]  r_leeway;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_max_speed <= MAX_SPEED_RESET;
            r_leeway    <= LEEWAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN:      r_gain      <= i_cfg_data;
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[14:0];
                CFG_LEEWAY:    r_leeway    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.gain    = r_gain;
        o_cfg.max_eff = (r_max_speed > MAX_DRIVE) ? MAX_DRIVE : r_max_speed;
        o_cfg.leeway  = r_leeway;
    end

endmodule

// ===== design/epc_law.sv =====
`timescale 1ns / 1ps
// Elevator position controller: controller state, homing, presets and the
// proportional law with clamp. Depends on epc_pkg.
module epc_law import epc_pkg::*; #(
    parameter int NUM_PRESETS = 6,
    parameter int POS_WIDTH   = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int P      = POS_WIDTH;
    localparam int EW     = (POS_WIDTH > 16) ? POS_WIDTH : 16;
    localparam int STEP_W = $clog2(NUM_PRESETS);
    localparam int PW     = POS_WIDTH + 18;

    localparam logic signed [P-1:0] PMAX  = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0] PMIN  = {1'b1, {(P-1){1'b0}}};
    localparam logic signed [EW:0]  XMAX  = (EW+1)'(PMAX);
    localparam logic signed [EW:0]  XMIN  = (EW+1)'(PMIN);
    localparam logic signed [P:0]   DMAX  = (P+1)'(PMAX);
    localparam logic signed [P:0]   DMIN  = (P+1)'(PMIN);
    localparam logic [STEP_W-1:0]   STEP_LAST = STEP_W'(NUM_PRESETS - 1);
    localparam logic [3:0]          PRESET_CNT = 4'(NUM_PRESETS);

    logic signed [P-1:0] r_target, n_target;
    logic signed [P-1:0] r_offset, n_offset;
    logic                r_homing, n_homing;
    logic                r_btn, n_btn;
    logic [STEP_W-1:0]   r_step, n_step;

    function automatic logic signed [P-1:0] f_sat_in(input logic signed [15:0] v);
        logic signed [EW:0] x;
        x = (EW+1)'(v);
        if (x > XMAX)
            f_sat_in = PMAX;
        else if (x < XMIN)
            f_sat_in = PMIN;
        else
            f_sat_in = x[P-1:0];
    endfunction

    logic signed [P-1:0]  raw, tv, pos;
    logic signed [P:0]    diff, err;
    logic [P:0]           mag;
    logic                 at;
    logic signed [PW-1:0] prod, prod_adj, quot, msx;
    logic signed [15:0]   ms16, drv;

    always_comb begin
        n_target = r_target;
        n_offset = r_offset;
        n_homing = r_homing;
        n_btn    = r_btn;
        n_step   = r_step;
        raw      = f_sat_in(i_item.position);
        tv       = f_sat_in(i_item.target_value);

        case (i_item.kind)
            KIND_SET: begin
                n_target = tv;
            end
            KIND_PRESET: begin
                if (i_item.preset_index != 3'd0 && {1'b0, i_item.preset_index} <= PRESET_CNT)
                    n_target = P'(preset_height({1'b0, i_item.preset_index}));
            end
            KIND_HOME: begin
                n_homing = 1'b1;
            end
            default: begin
                if (i_item.button_pressed && !r_btn) begin
                    n_step   = (r_step == STEP_LAST) ? '0 : r_step + 1'b1;
                    n_target = P'(preset_height(4'(n_step) + 4'd1));
                end
                n_btn = i_item.button_pressed;
                if (r_homing && !i_item.limit_clear) begin
                    n_homing = 1'b0;
                    n_offset = raw;
                    n_target = '0;
                end
            end
        endcase

        diff = (P+1)'(raw) - (P+1)'(n_offset);
        if (diff > DMAX)
            pos = PMAX;
        else if (diff < DMIN)
            pos = PMIN;
        else
            pos = diff[P-1:0];

        err = (P+1)'(n_target) - (P+1)'(pos);
        mag = err[P] ? (P+1)'(-err) : err;
        at  = mag < (P+1)'(i_cfg.leeway);

        prod     = PW'(err) * PW'($signed({1'b0, i_cfg.gain}));
        prod_adj = prod[PW-1] ? prod + PW'(3) : prod;
        quot     = prod_adj >>> 2;
        msx      = PW'($signed({1'b0, i_cfg.max_eff}));
        ms16     = $signed({1'b0, i_cfg.max_eff});
        if (quot > msx)
            drv = ms16;
        else if (quot < -msx)
            drv = -ms16;
        else
            drv = quot[15:0];

        if (r_homing && i_item.limit_clear) begin
            o_res.drive     = 16'sd0 - $signed({2'b0, i_cfg.max_eff[14:1]});
            o_res.brake     = 1'b0;
            o_res.homing    = 1'b1;
            o_res.at_target = 1'b0;
        end else begin
            o_res.drive     = drv;
            o_res.brake     = at;
            o_res.homing    = 1'b0;
            o_res.at_target = at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_offset <= '0;
            r_homing <= 1'b0;
            r_btn    <= 1'b0;
            r_step   <= '0;
        end else if (i_go) begin
            r_target <= n_target;
            r_offset <= n_offset;
            r_homing <= n_homing;
            r_btn    <= n_btn;
            r_step   <= n_step;
        end
    end

endmodule

// ===== bench/elevator_position_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for elevator_position_controller: directed table, then
// random phases over several register settings. Depends on epc_pkg and the RTL.
module elevator_position_controller_tb;
    import epc_pkg::*;

    localparam int NUM_PRESETS = 6;
    localparam int PRESET_STEP = 128;
    localparam int ITEMS_PER_PHASE = 254;
    localparam int NUM_PHASES = 7;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_kind = 2'd0;
    logic signed [15:0] i_position = '0;
    logic               i_limit_clear = 1'b0;
    logic               i_button_pressed = 1'b0;
    logic signed [15:0] i_target_value = '0;
    logic [2:0]         i_preset_index = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_drive;
    logic               o_brake;
    logic               o_homing;
    logic               o_at_target;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    // controller image
    logic signed [15:0] tgt_q = '0;
    logic signed [15:0] ofs_q = '0;
    bit                 homing_q = 1'b0;
    bit                 btn_last_q = 1'b0;
    logic [2:0]         step_q = '0;
    logic [15:0]        gain_r = GAIN_RESET;
    logic [14:0]        maxsp_r = MAX_SPEED_RESET;
    logic [7:0]         leeway_r = LEEWAY_RESET;

    t_result motor_cmd_q[$];
    t_row    directed[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  commands_sent = 0;
    int  reg_writes = 0;
    int  hold_req = 0;
    int  hold_done = 0;
    int  hold_left = 0;
    bit  no_idle = 1'b0;

    elevator_position_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_limit_clear   (i_limit_clear),
        .i_button_pressed(i_button_pressed),
        .i_target_value  (i_target_value),
        .i_preset_index  (i_preset_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive         (o_drive),
        .o_brake         (o_brake),
        .o_homing        (o_homing),
        .o_at_target     (o_at_target),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_item mk(t_kind k, int pos, bit lc, bit btn, int tv, int pidx);
        t_item it;
        it.kind           = k;
        it.position       = 16'(pos);
        it.limit_clear    = lc;
        it.button_pressed = btn;
        it.target_value   = 16'(tv);
        it.preset_index   = 3'(pidx);
        return it;
    endfunction

    function automatic t_result res(int d, bit b, bit h, bit a);
        t_result r;
        r.drive     = 16'(d);
        r.brake     = b;
        r.homing    = h;
        r.at_target = a;
        return r;
    endfunction

    // Advances the controller image by one item; returns 1 when a result is due.
    function automatic bit step_controller(input t_item it, output t_result r);
        longint raw, ofs, tgt, pos, err, mag, drv, ms, g, lee;
        r = '0;
        case (it.kind)
            KIND_SET: begin
                tgt_q = it.target_value;
                return 1'b0;
            end
            KIND_PRESET: begin
                if (it.preset_index >= 1 && it.preset_index <= NUM_PRESETS)
                    tgt_q = 16'(int'(it.preset_index) * PRESET_STEP);
                return 1'b0;
            end
            KIND_HOME: begin
                homing_q = 1'b1;
                return 1'b0;
            end
            default: begin
            end
        endcase
        if (it.button_pressed && !btn_last_q) begin
            step_q = step_q + 3'd1;
            if (step_q >= NUM_PRESETS)
                step_q = '0;
            tgt_q = 16'((int'(step_q) + 1) * PRESET_STEP);
        end
        btn_last_q = it.button_pressed;
        ms = maxsp_r;
        if (ms > MAX_DRIVE)
            ms = MAX_DRIVE;
        if (homing_q) begin
            if (it.limit_clear) begin
                r.drive  = 16'(-(ms / 2));
                r.homing = 1'b1;
                return 1'b1;
            end
            homing_q = 1'b0;
            ofs_q    = it.position;
            tgt_q    = '0;
        end
        raw = it.position;
        ofs = ofs_q;
        tgt = tgt_q;
        g   = gain_r;
        lee = leeway_r;
        pos = raw - ofs;
        if (pos > 32767)
            pos = 32767;
        if (pos < -32768)
            pos = -32768;
        err = tgt - pos;
        mag = (err < 0) ? -err : err;
        drv = (err * g) / 4;
        if (drv > ms)
            drv = ms;
        if (drv < -ms)
            drv = -ms;
        r.drive     = 16'(drv);
        r.brake     = (mag < lee);
        r.at_target = (mag < lee);
        return 1'b1;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    r;
        int    near;
        r = $urandom_range(0, 99);
        if (r < 72)
            it.kind = KIND_TICK;
        else if (r < 84)
            it.kind = KIND_SET;
        else if (r < 93)
            it.kind = KIND_PRESET;
        else
            it.kind = KIND_HOME;
        near = int'(ofs_q) + int'(tgt_q) + int'($urandom_range(0, 600)) - 300;
        it.position = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(near);
        it.limit_clear = homing_q ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
        it.button_pressed = btn_last_q ^ ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0)
            it.target_value = 16'($urandom);
        else
            it.target_value = 16'(int'($urandom_range(0, 2000)) - 1000);
        it.preset_index = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_result want);
        t_result r;
        while (!no_idle && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= it.kind;
        i_position       <= it.position;
        i_limit_clear    <= it.limit_clear;
        i_button_pressed <= it.button_pressed;
        i_target_value   <= it.target_value;
        i_preset_index   <= it.preset_index;
        do @(posedge i_clk); while (!o_in_ready);
        if (step_controller(it, r))
            motor_cmd_q.push_back(typed ? want : r);
        else
            commands_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN:      gain_r = val;
            CFG_MAX_SPEED: maxsp_r = val[14:0];
            CFG_LEEWAY:    leeway_r = val[7:0];
            default: begin
            end
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Sender pause: all results back, then let any trailing command retire.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (motor_cmd_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (motor_cmd_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result drive=%0d brake=%0b homing=%0b at=%0b",
                         $time, o_drive, o_brake, o_homing, o_at_target);
            end else begin
                e = motor_cmd_q.pop_front();
                results_checked++;
                if (o_drive !== e.drive) begin
                    mismatches++;
                    $display("%0t: drive expected %0d actual %0d", $time, e.drive, o_drive);
                end
                if (o_brake !== e.brake) begin
                    mismatches++;
                    $display("%0t: brake expected %0b actual %0b", $time, e.brake, o_brake);
                end
                if (o_homing !== e.homing) begin
                    mismatches++;
                    $display("%0t: homing expected %0b actual %0b", $time, e.homing, o_homing);
                end
                if (o_at_target !== e.at_target) begin
                    mismatches++;
                    $display("%0t: at_target expected %0b actual %0b",
                             $time, e.at_target, o_at_target);
                end
            end
        end
        if (hold_left == 0 && hold_req != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (no_idle) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 34);
        end
    end

    initial begin
        #2000000;
        $display("elevator_position_controller_tb: FAIL");
        $finish;
    end

    initial begin
        directed.push_back('{mk(KIND_TICK, 0, 1, 0, 0, 0), 1'b1, res(0, 1, 0, 1)});
        directed.push_back('{mk(KIND_SET, 0, 1, 0, 32767, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, -32768, 1, 0, 0, 0), 1'b1, res(8192, 0, 0, 0)});
        directed.push_back('{mk(KIND_SET, 0, 1, 0, -32768, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 32767, 1, 0, 0, 0), 1'b1, res(-8192, 0, 0, 0)});
        directed.push_back('{mk(KIND_SET, 0, 1, 0, 100, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 93, 1, 0, 0, 0), 1'b1, res(448, 1, 0, 1)});
        directed.push_back('{mk(KIND_TICK, 92, 1, 0, 0, 0), 1'b1, res(512, 0, 0, 0)});
        directed.push_back('{mk(KIND_TICK, 108, 1, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_PRESET, 0, 1, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_PRESET, 0, 1, 0, 0, 7), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 100, 1, 0, 0, 0), 1'b1, res(0, 1, 0, 1)});
        directed.push_back('{mk(KIND_PRESET, 0, 1, 0, 0, 6), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 768, 1, 0, 0, 0), 1'b1, res(0, 1, 0, 1)});
        directed.push_back('{mk(KIND_TICK, 700, 1, 1, 0, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 700, 1, 1, 0, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 700, 1, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_HOME, 0, 1, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 5000, 1, 0, 0, 0), 1'b1, res(-4096, 0, 1, 0)});
        directed.push_back('{mk(KIND_HOME, 0, 1, 0, 0, 0), 1'b0, '0});
        // button edge while homing still moves the target
        directed.push_back('{mk(KIND_TICK, 5000, 1, 1, 0, 0), 1'b1, res(-4096, 0, 1, 0)});
        directed.push_back('{mk(KIND_TICK, 5000, 0, 0, 0, 0), 1'b1, res(0, 1, 0, 1)});
        directed.push_back('{mk(KIND_TICK, -32768, 0, 0, 0, 0), 1'b1, res(8192, 0, 0, 0)});
        directed.push_back('{mk(KIND_PRESET, 0, 1, 0, 0, 3), 1'b0, '0});
        directed.push_back('{mk(KIND_TICK, 5100, 1, 0, 0, 0), 1'b0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n])
            send_item(directed[n].it, directed[n].typed, directed[n].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: begin
                    write_reg(CFG_GAIN, 16'hFFFF);
                    write_reg(CFG_MAX_SPEED, 16'(MAX_DRIVE));
                    write_reg(CFG_LEEWAY, 16'd255);
                end
                2: begin
                    write_reg(CFG_GAIN, 16'd0);
                    write_reg(CFG_MAX_SPEED, 16'd0);
                    write_reg(CFG_LEEWAY, 16'd0);
                end
                3: begin
                    write_reg(CFG_GAIN, 16'd1024);
                    write_reg(CFG_MAX_SPEED, 16'h7FFF);
                    write_reg(CFG_LEEWAY, 16'd30);
                end
                4: begin
                    write_reg(CFG_GAIN, 16'($urandom_range(0, 65535)));
                    write_reg(CFG_MAX_SPEED, 16'($urandom));
                    write_reg(CFG_LEEWAY, 16'($urandom));
                    write_reg(CFG_SPARE, 16'($urandom));
                end
                5: begin
                    write_reg(CFG_GAIN, 16'd128);
                    write_reg(CFG_MAX_SPEED, 16'd1);
                    write_reg(CFG_LEEWAY, 16'd1);
                end
                6: begin
                    write_reg(CFG_GAIN, 16'd300);
                    write_reg(CFG_MAX_SPEED, 16'(int'(MAX_DRIVE) + 1));
                    write_reg(CFG_LEEWAY, 16'd12);
                end
                default: begin
                end
            endcase
            if (p == 1)
                hold_req++;
            no_idle = (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(rand_item(), 1'b0, '0);
            drain();
        end
        no_idle = 1'b0;

        $display("%0d control results checked, %0d commands, %0d register writes",
                 results_checked, commands_sent, reg_writes);
        $display("covered homing, preset stepping, clamp and saturation over %0d settings",
                 NUM_PHASES);
        if (mismatches == 0)
            $display("elevator_position_controller_tb: PASS");
        else
            $display("elevator_position_controller_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/epc_pkg.sv
design/epc_cfg.sv
design/epc_law.sv
design/elevator_position_controller.sv
bench/elevator_position_controller_tb.sv
